### rtl/cco_pkg.sv
// capsule pair overlap: shared widths, codes and payload types
// no dependencies; imported by the interfaces and every rtl module
package cco_pkg;

  localparam int CW   = 20;            // coordinate width
  localparam int PTW  = 3 * CW;        // packed point word
  localparam int RIW  = 19;            // radius width
  localparam int RADW = RIW + 1;       // radius sum width
  localparam int DW   = CW + 1;        // coordinate difference width
  localparam int PB   = 16;            // parameter fraction bits
  localparam int QW   = PB + 1;        // parameter width, 0 to one inclusive
  localparam int DOTW = 2 * DW + 2;    // dot product width
  localparam int WW   = 2 * DOTW;      // wide determinant width
  localparam int XW   = DOTW + PB + 1; // scaled numerator width
  localparam int VW   = 2 * DW;        // unrounded separation width
  localparam int SEPW = DW + 1;        // rounded separation width
  localparam int SOW  = DW;            // one lane of the packed separation
  localparam int SPW  = 3 * SOW;       // packed separation width
  localparam int SQW  = 2 * SEPW + 2;  // squared distance width

  localparam logic [QW-1:0] PARAM_ONE = QW'(1) << PB;

  // quotient selection codes
  localparam logic [1:0] Q_ZERO = 2'd0;
  localparam logic [1:0] Q_ONE  = 2'd1;
  localparam logic [1:0] Q_DIV  = 2'd2;

  typedef logic signed [DW-1:0] diff_t;

  typedef struct packed {
    diff_t [2:0]     d1;
    diff_t [2:0]     d2;
    diff_t [2:0]     r;
    logic [RADW-1:0] rad;
  } geom_t;

  typedef struct packed {
    logic signed [DOTW-1:0] a;
    logic signed [DOTW-1:0] b;
    logic signed [DOTW-1:0] c;
    logic signed [DOTW-1:0] e;
    logic signed [DOTW-1:0] f;
  } dots_t;

  typedef struct packed {
    dots_t                dots;
    logic signed [WW-1:0] den;
    logic signed [WW-1:0] num;
    geom_t                geom;
  } front_t;

  typedef struct packed {
    dots_t           dots;
    logic [QW-1:0]   s;
    geom_t           geom;
  } wdiv_t;

  typedef struct packed {
    logic [QW-1:0] s;
    logic [QW-1:0] t;
    geom_t         geom;
  } solve_t;

endpackage

### rtl/cco_if.sv
// capsule pair overlap: valid/ready stream interfaces for items and results
// depends on cco_pkg
interface cco_in_if import cco_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PTW-1:0]  first_start;
  logic [PTW-1:0]  first_end;
  logic [PTW-1:0]  second_start;
  logic [PTW-1:0]  second_end;
  logic [RIW-1:0]  first_radius;
  logic [RIW-1:0]  second_radius;

  modport source (output valid, first_start, first_end, second_start, second_end,
                  first_radius, second_radius, input ready);
  modport sink (input valid, first_start, first_end, second_start, second_end,
                first_radius, second_radius, output ready);
endinterface

interface cco_out_if import cco_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            hit;
  logic [SPW-1:0]  separation;
  logic [QW-1:0]   first_param;
  logic [QW-1:0]   second_param;

  modport source (output valid, hit, separation, first_param, second_param, input ready);
  modport sink (input valid, hit, separation, first_param, second_param, output ready);
endinterface

### rtl/cco_front.sv
// capsule pair overlap: differences, dot products and the wide determinants
// depends on cco_pkg; five register stages
module cco_front import cco_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  logic [PTW-1:0] p1_start,
  input  logic [PTW-1:0] p1_end,
  input  logic [PTW-1:0] p2_start,
  input  logic [PTW-1:0] p2_end,
  input  logic [RIW-1:0] rad1,
  input  logic [RIW-1:0] rad2,
  output logic           dn_valid,
  input  logic           dn_ready,
  output front_t         dn_data
);

  localparam int NS = 5;
  localparam int HW = DOTW / 2;

  typedef struct packed {
    logic [DOTW-1:0] hh;
    logic [DOTW-1:0] hl;
    logic [DOTW-1:0] lh;
    logic [DOTW-1:0] ll;
  } pp4_t;

  function automatic diff_t csub(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return {x[CW-1], x} - {y[CW-1], y};
  endfunction

  function automatic logic signed [DOTW-1:0] dot3(input diff_t x0, input diff_t x1,
                                                  input diff_t x2, input diff_t y0,
                                                  input diff_t y1, input diff_t y2);
    logic signed [DOTW-1:0] p0, p1, p2;
    p0 = x0 * y0;
    p1 = x1 * y1;
    p2 = x2 * y2;
    return p0 + p1 + p2;
  endfunction

  function automatic logic [DOTW-1:0] mag(input logic signed [DOTW-1:0] v);
    return v[DOTW-1] ? -v : v;
  endfunction

  function automatic pp4_t split_mul(input logic [DOTW-1:0] x, input logic [DOTW-1:0] y);
    pp4_t p;
    p.hh = x[DOTW-1:HW] * y[DOTW-1:HW];
    p.hl = x[DOTW-1:HW] * y[HW-1:0];
    p.lh = x[HW-1:0] * y[DOTW-1:HW];
    p.ll = x[HW-1:0] * y[HW-1:0];
    return p;
  endfunction

  function automatic logic signed [WW-1:0] join_pp(input pp4_t p, input logic neg);
    logic [WW-1:0] m;
    m = {p.hh, p.ll} + {{HW{1'b0}}, p.hl, {HW{1'b0}}} + {{HW{1'b0}}, p.lh, {HW{1'b0}}};
    return neg ? -m : m;
  endfunction

  logic [NS-1:0]        vld_r;
  logic                 en;
  geom_t                g0_nxt, g0_r, g1_r, g2_r, g3_r, g4_r;
  dots_t                dt1_nxt, dt1_r, dt2_r, dt3_r, dt4_r;
  pp4_t                 pp_r [4];
  logic [3:0]           neg_r;
  logic signed [WW-1:0] prod_r [4];
  logic signed [WW-1:0] den_r, num_r;

  assign en       = !vld_r[NS-1] || dn_ready;
  assign up_ready = en;
  assign dn_valid = vld_r[NS-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      g0_nxt.d1[k] = csub(p1_end[k*CW +: CW], p1_start[k*CW +: CW]);
      g0_nxt.d2[k] = csub(p2_end[k*CW +: CW], p2_start[k*CW +: CW]);
      g0_nxt.r[k]  = csub(p1_start[k*CW +: CW], p2_start[k*CW +: CW]);
    end
    g0_nxt.rad = {1'b0, rad1} + {1'b0, rad2};
  end

  always_comb begin
    dt1_nxt.a = dot3(g0_r.d1[0], g0_r.d1[1], g0_r.d1[2], g0_r.d1[0], g0_r.d1[1], g0_r.d1[2]);
    dt1_nxt.e = dot3(g0_r.d2[0], g0_r.d2[1], g0_r.d2[2], g0_r.d2[0], g0_r.d2[1], g0_r.d2[2]);
    dt1_nxt.f = dot3(g0_r.d2[0], g0_r.d2[1], g0_r.d2[2], g0_r.r[0], g0_r.r[1], g0_r.r[2]);
    dt1_nxt.c = dot3(g0_r.d1[0], g0_r.d1[1], g0_r.d1[2], g0_r.r[0], g0_r.r[1], g0_r.r[2]);
    dt1_nxt.b = dot3(g0_r.d1[0], g0_r.d1[1], g0_r.d1[2], g0_r.d2[0], g0_r.d2[1], g0_r.d2[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], up_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g0_r  <= g0_nxt;
      g1_r  <= g0_r;
      dt1_r <= dt1_nxt;
      // magnitude partial products: a*e, b*b, b*f, c*e
      pp_r[0]  <= split_mul(mag(dt1_r.a), mag(dt1_r.e));
      pp_r[1]  <= split_mul(mag(dt1_r.b), mag(dt1_r.b));
      pp_r[2]  <= split_mul(mag(dt1_r.b), mag(dt1_r.f));
      pp_r[3]  <= split_mul(mag(dt1_r.c), mag(dt1_r.e));
      neg_r[0] <= dt1_r.a[DOTW-1] ^ dt1_r.e[DOTW-1];
      neg_r[1] <= 1'b0;
      neg_r[2] <= dt1_r.b[DOTW-1] ^ dt1_r.f[DOTW-1];
      neg_r[3] <= dt1_r.c[DOTW-1] ^ dt1_r.e[DOTW-1];
      g2_r  <= g1_r;
      dt2_r <= dt1_r;
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= join_pp(pp_r[k], neg_r[k]);
      end
      g3_r  <= g2_r;
      dt3_r <= dt2_r;
      den_r <= prod_r[0] - prod_r[1];
      num_r <= prod_r[2] - prod_r[3];
      g4_r  <= g3_r;
      dt4_r <= dt3_r;
    end
  end

  always_comb begin
    dn_data.dots = dt4_r;
    dn_data.den  = den_r;
    dn_data.num  = num_r;
    dn_data.geom = g4_r;
  end

endmodule

### rtl/cco_wdiv.sv
// capsule pair overlap: clamped first-segment parameter from the wide ratio
// depends on cco_pkg; one classify stage then one quotient bit per stage
module cco_wdiv import cco_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  front_t up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output wdiv_t  dn_data
);

  localparam int NS = PB + 1;

  logic [NS-1:0] vld_r;
  logic          en;
  logic [1:0]    mode_nxt;
  logic [WW-1:0] rem_r  [NS];
  logic [WW-1:0] den_r  [NS];
  logic [PB-1:0] q_r    [NS];
  logic [1:0]    mode_r [NS];
  dots_t         dots_r [NS];
  geom_t         geom_r [NS];
  logic [WW-1:0] sh     [PB];
  logic [PB-1:0] ge;

  assign en       = !vld_r[NS-1] || dn_ready;
  assign up_ready = en;
  assign dn_valid = vld_r[NS-1];

  always_comb begin
    if (up_data.den == 0 || up_data.num <= 0) begin
      mode_nxt = Q_ZERO;
    end else if (up_data.num >= up_data.den) begin
      mode_nxt = Q_ONE;
    end else begin
      mode_nxt = Q_DIV;
    end
  end

  always_comb begin
    for (int i = 0; i < PB; i++) begin
      sh[i] = rem_r[i] << 1;
      ge[i] = sh[i] >= den_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], up_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= up_data.num;
      den_r[0]  <= up_data.den;
      q_r[0]    <= '0;
      mode_r[0] <= mode_nxt;
      dots_r[0] <= up_data.dots;
      geom_r[0] <= up_data.geom;
      for (int i = 0; i < PB; i++) begin
        rem_r[i+1]  <= ge[i] ? sh[i] - den_r[i] : sh[i];
        den_r[i+1]  <= den_r[i];
        q_r[i+1]    <= {q_r[i][PB-2:0], ge[i]};
        mode_r[i+1] <= mode_r[i];
        dots_r[i+1] <= dots_r[i];
        geom_r[i+1] <= geom_r[i];
      end
    end
  end

  always_comb begin
    dn_data.dots = dots_r[NS-1];
    dn_data.geom = geom_r[NS-1];
    case (mode_r[NS-1])
      Q_ONE:   dn_data.s = PARAM_ONE;
      Q_DIV:   dn_data.s = {1'b0, q_r[NS-1]};
      default: dn_data.s = '0;
    endcase
  end

endmodule

### rtl/cco_tsolve.sv
// capsule pair overlap: second-segment numerator, case selection and the
// shared narrow divider that finishes s or t; depends on cco_pkg
module cco_tsolve import cco_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  wdiv_t  up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output solve_t dn_data
);

  localparam int NS = PB + 3;
  localparam int ND = PB + 1;

  logic [NS-1:0]          vld_r;
  logic                   en;
  // numerator stage
  logic signed [XW-1:0]   tnom_nxt, tnom_r;
  logic [QW-1:0]          s0_r;
  dots_t                  dots0_r;
  geom_t                  g0_r;
  // selection stage
  logic signed [DOTW-1:0] nc, bmc;
  logic signed [XW-1:0]   ncx, bmcx, fx, eone;
  logic signed [XW-1:0]   x_nxt, x1_r;
  logic [DOTW-1:0]        dv_nxt, dv1_r;
  logic                   tot_nxt, tot1_r;
  logic [QW-1:0]          fix_nxt, fix1_r;
  geom_t                  g1_r;
  // divider
  logic signed [XW-1:0]   dsh;
  logic [1:0]             mode_nxt;
  logic [DOTW-1:0]        rem_r  [ND];
  logic [PB-1:0]          xl_r   [ND];
  logic [DOTW-1:0]        dv_r   [ND];
  logic [PB-1:0]          q_r    [ND];
  logic [1:0]             mode_r [ND];
  logic                   tot_r  [ND];
  logic [QW-1:0]          fix_r  [ND];
  geom_t                  geom_r [ND];
  logic [DOTW:0]          sh     [PB];
  logic [DOTW:0]          dif    [PB];
  logic [PB-1:0]          ge;
  logic [QW-1:0]          qv;

  assign en       = !vld_r[NS-1] || dn_ready;
  assign up_ready = en;
  assign dn_valid = vld_r[NS-1];

  assign tnom_nxt = up_data.dots.b * $signed({1'b0, up_data.s})
                  + (XW'(up_data.dots.f) <<< PB);

  always_comb begin
    nc   = -dots0_r.c;
    bmc  = dots0_r.b - dots0_r.c;
    ncx  = nc;
    ncx  = ncx <<< PB;
    bmcx = bmc;
    bmcx = bmcx <<< PB;
    fx   = dots0_r.f;
    fx   = fx <<< PB;
    eone = $signed({1'b0, dots0_r.e, {PB{1'b0}}});
    if (dots0_r.a == 0 && dots0_r.e == 0) begin
      x_nxt = '0;   dv_nxt = dots0_r.e; tot_nxt = 1'b1; fix_nxt = '0;
    end else if (dots0_r.a == 0) begin
      x_nxt = fx;   dv_nxt = dots0_r.e; tot_nxt = 1'b1; fix_nxt = '0;
    end else if (dots0_r.e == 0) begin
      x_nxt = ncx;  dv_nxt = dots0_r.a; tot_nxt = 1'b0; fix_nxt = '0;
    end else if (tnom_r < 0) begin
      // t clamps low, redo s against the first segment alone
      x_nxt = ncx;  dv_nxt = dots0_r.a; tot_nxt = 1'b0; fix_nxt = '0;
    end else if (tnom_r > eone) begin
      // t clamps high
      x_nxt = bmcx; dv_nxt = dots0_r.a; tot_nxt = 1'b0; fix_nxt = PARAM_ONE;
    end else begin
      x_nxt = tnom_r; dv_nxt = dots0_r.e; tot_nxt = 1'b1; fix_nxt = s0_r;
    end
  end

  always_comb begin
    dsh = $signed({1'b0, dv1_r, {PB{1'b0}}});
    if (x1_r <= 0) begin
      mode_nxt = Q_ZERO;
    end else if (x1_r >= dsh) begin
      mode_nxt = Q_ONE;
    end else begin
      mode_nxt = Q_DIV;
    end
  end

  always_comb begin
    for (int i = 0; i < PB; i++) begin
      sh[i]  = {rem_r[i], xl_r[i][PB-1]};
      dif[i] = sh[i] - {1'b0, dv_r[i]};
      ge[i]  = sh[i] >= {1'b0, dv_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], up_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tnom_r    <= tnom_nxt;
      s0_r      <= up_data.s;
      dots0_r   <= up_data.dots;
      g0_r      <= up_data.geom;
      x1_r      <= x_nxt;
      dv1_r     <= dv_nxt;
      tot1_r    <= tot_nxt;
      fix1_r    <= fix_nxt;
      g1_r      <= g0_r;
      rem_r[0]  <= x1_r[PB +: DOTW];
      xl_r[0]   <= x1_r[PB-1:0];
      dv_r[0]   <= dv1_r;
      q_r[0]    <= '0;
      mode_r[0] <= mode_nxt;
      tot_r[0]  <= tot1_r;
      fix_r[0]  <= fix1_r;
      geom_r[0] <= g1_r;
      for (int i = 0; i < PB; i++) begin
        rem_r[i+1]  <= ge[i] ? dif[i][DOTW-1:0] : sh[i][DOTW-1:0];
        xl_r[i+1]   <= {xl_r[i][PB-2:0], 1'b0};
        dv_r[i+1]   <= dv_r[i];
        q_r[i+1]    <= {q_r[i][PB-2:0], ge[i]};
        mode_r[i+1] <= mode_r[i];
        tot_r[i+1]  <= tot_r[i];
        fix_r[i+1]  <= fix_r[i];
        geom_r[i+1] <= geom_r[i];
      end
    end
  end

  always_comb begin
    case (mode_r[ND-1])
      Q_ONE:   qv = PARAM_ONE;
      Q_DIV:   qv = {1'b0, q_r[ND-1]};
      default: qv = '0;
    endcase
    dn_data.s    = tot_r[ND-1] ? fix_r[ND-1] : qv;
    dn_data.t    = tot_r[ND-1] ? qv : fix_r[ND-1];
    dn_data.geom = geom_r[ND-1];
  end

endmodule

### rtl/cco_finish.sv
// capsule pair overlap: separation, rounding, squared distance and hit test
// depends on cco_pkg; last stage is the result register
module cco_finish import cco_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  solve_t         up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output logic           hit,
  output logic [SPW-1:0] separation,
  output logic [QW-1:0]  first_param,
  output logic [QW-1:0]  second_param
);

  localparam int NS = 4;
  localparam logic signed [VW-1:0] HALF_LSB = VW'(1) <<< (PB - 1);

  function automatic logic signed [VW-1:0] lin(input diff_t r, input diff_t d1,
                                               input diff_t d2, input logic [QW-1:0] s,
                                               input logic [QW-1:0] t);
    logic signed [VW-1:0] rv, p1, p2;
    rv = r;
    rv = rv <<< PB;
    p1 = d1 * $signed({1'b0, s});
    p2 = d2 * $signed({1'b0, t});
    return rv + p1 - p2;
  endfunction

  logic [NS-1:0]          vld_r;
  logic                   en;
  logic signed [VW-1:0]   v0_r [3];
  logic [RADW-1:0]        rad0_r, rad1_r;
  logic [QW-1:0]          s0_r, t0_r, s1_r, t1_r, s2_r, t2_r, s3_r, t3_r;
  logic signed [VW-1:0]   h [3];
  logic signed [SEPW-1:0] sep1_r [3];
  logic signed [SEPW-1:0] sep2_r [3];
  logic signed [SQW-1:0]  sq [3];
  logic [SQW-1:0]         dist_nxt, dist2_r, rsq2_r;
  logic                   hit_r;
  logic [SPW-1:0]         sep3_r;

  assign en       = !vld_r[NS-1] || dn_ready;
  assign up_ready = en;
  assign dn_valid = vld_r[NS-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      // round half up: add half an lsb, arithmetic shift
      h[k]  = v0_r[k] + HALF_LSB;
      sq[k] = sep1_r[k] * sep1_r[k];
    end
    dist_nxt = sq[0] + sq[1] + sq[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], up_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        v0_r[k]   <= lin(up_data.geom.r[k], up_data.geom.d1[k], up_data.geom.d2[k],
                         up_data.s, up_data.t);
        sep1_r[k] <= h[k][PB +: SEPW];
        sep2_r[k] <= sep1_r[k];
      end
      rad0_r  <= up_data.geom.rad;
      s0_r    <= up_data.s;
      t0_r    <= up_data.t;
      rad1_r  <= rad0_r;
      s1_r    <= s0_r;
      t1_r    <= t0_r;
      dist2_r <= dist_nxt;
      rsq2_r  <= rad1_r * rad1_r;
      s2_r    <= s1_r;
      t2_r    <= t1_r;
      hit_r   <= dist2_r <= rsq2_r;
      sep3_r  <= {sep2_r[2][SOW-1:0], sep2_r[1][SOW-1:0], sep2_r[0][SOW-1:0]};
      s3_r    <= s2_r;
      t3_r    <= t2_r;
    end
  end

  assign hit          = hit_r;
  assign separation   = sep3_r;
  assign first_param  = s3_r;
  assign second_param = t3_r;

endmodule

### rtl/capsule_capsule_overlap_top.sv
// capsule pair overlap test, fully pipelined
// pipeline: 45 register stages; the last one is the result register on out_chan
// throughput: one capsule pair per cycle unless out_chan stalls; the 16-stage wide divider and the
// 16-stage narrow divider are each one quotient bit per stage
// reset: synchronous active-low rst_n clears only the stage valid bits
module capsule_capsule_overlap_top import cco_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cco_in_if.sink    in_chan,
  cco_out_if.source out_chan
);

  // front end: 5 stages
  //   coordinate differences, the five dot products a b c e f, split partial
  //   products of the 88-bit determinants, recombination, den and num
  logic   fr_valid, fr_ready;
  front_t fr_data;

  // wide divider: 17 stages
  //   s = clamp((b*f - c*e) / (a*e - b*b)) truncated to q1.16
  logic   wd_valid, wd_ready;
  wdiv_t  wd_data;

  // second solve: 19 stages
  //   t numerator b*s + f, picks which parameter is clamped and which one
  //   the narrow divider produces, then 16 quotient bits
  logic   ts_valid, ts_ready;
  solve_t ts_data;

  cco_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_chan.valid),
    .up_ready (in_chan.ready),
    .p1_start (in_chan.first_start),
    .p1_end   (in_chan.first_end),
    .p2_start (in_chan.second_start),
    .p2_end   (in_chan.second_end),
    .rad1     (in_chan.first_radius),
    .rad2     (in_chan.second_radius),
    .dn_valid (fr_valid),
    .dn_ready (fr_ready),
    .dn_data  (fr_data)
  );

  cco_wdiv u_wdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fr_valid),
    .up_ready (fr_ready),
    .up_data  (fr_data),
    .dn_valid (wd_valid),
    .dn_ready (wd_ready),
    .dn_data  (wd_data)
  );

  cco_tsolve u_tsolve (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (wd_valid),
    .up_ready (wd_ready),
    .up_data  (wd_data),
    .dn_valid (ts_valid),
    .dn_ready (ts_ready),
    .dn_data  (ts_data)
  );

  // back end: 4 stages, the last one is the result register on out_chan
  cco_finish u_finish (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (ts_valid),
    .up_ready     (ts_ready),
    .up_data      (ts_data),
    .dn_valid     (out_chan.valid),
    .dn_ready     (out_chan.ready),
    .hit          (out_chan.hit),
    .separation   (out_chan.separation),
    .first_param  (out_chan.first_param),
    .second_param (out_chan.second_param)
  );

endmodule
